>>> rtl/btf_pkg.sv
// Shared constants, widths and tables for the bearing-to-fixed-point block.
`default_nettype none

package btf_pkg;

  // Number of CORDIC micro-rotations in each chain
  localparam int CORDIC_STAGES = 18;

  // Field widths
  localparam int LAT_W  = 24;
  localparam int LON_W  = 25;
  localparam int DEG_W  = 26;
  localparam int TURN_W = 32;
  localparam int FINE_W = 17;
  localparam int WHOLE_W = 9;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 25;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_LAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_LON = 2'd1;

  // Target point after reset (degrees, 16 fraction bits)
  localparam logic [LAT_W-1:0] TARGET_LAT_RESET = 24'd1403944;
  localparam logic [LON_W-1:0] TARGET_LON_RESET = 25'd2610050;

  // ceil(2^32 / 45): exact floor division by 45 for values below 2^26
  localparam logic [26:0] RECIP45 = 27'd95443718;

  // Binary angle constants
  localparam logic [TURN_W-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [TURN_W-1:0] HALF_TURN    = 32'h8000_0000;

  // CORDIC start vector, gain-compensated, 30 fraction bits
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

  // Output scaling
  localparam logic [FINE_W-1:0]  FINE_STEPS  = 17'd92160;
  localparam logic [WHOLE_W-1:0] WHOLE_STEPS = 9'd360;

  // Start to done, in clock cycles
  localparam int LATENCY = 2 * CORDIC_STAGES + 13;

  // atan(2^-i) in binary turn units
  localparam logic [TURN_W-1:0] TURN_ATAN [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1,
    32'd1,         32'd0
  };

endpackage

`default_nettype wire

>>> rtl/btf_turn.sv
// Degrees (16 fraction bits) to 32-bit binary turn angle, four pipeline stages.
`default_nettype none

module btf_turn import btf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic signed [DEG_W-1:0] deg,
  output logic                    out_valid,
  output logic [TURN_W-1:0]       turn
);

  logic [DEG_W-1:0] mag;
  logic             neg;

  logic        v0, neg0;
  logic [18:0] mh0;
  logic [19:0] ml0;
  logic [45:0] ph0;

  logic        v1, neg1;
  logic [13:0] qh1;
  logic [5:0]  rh1;
  logic [19:0] ml1;

  logic        v2, neg2;
  logic [13:0] qh2;
  logic [52:0] pl2;

  logic [TURN_W-1:0] q3;

  // magnitude; turn = round(mag * 2^16 / 360) = floor((mag * 2^13 + 22) / 45)
  always_comb begin
    neg = deg[DEG_W-1];
    mag = neg ? (~deg + 1'b1) : deg;
  end

  // stage 0: high half of the dividend times the reciprocal
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= in_valid;
    end
    neg0 <= neg;
    mh0  <= mag[25:7];
    ml0  <= {mag[6:0], 13'd22};
    ph0  <= 46'(mag[25:7]) * 46'(RECIP45);
  end

  // stage 1: high quotient and remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    neg1 <= neg0;
    qh1  <= ph0[45:32];
    rh1  <= 6'(mh0 - 19'(19'(ph0[45:32]) * 19'd45));
    ml1  <= ml0;
  end

  // stage 2: remainder joined with low half, times the reciprocal
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    neg2 <= neg1;
    qh2  <= qh1;
    pl2  <= 53'({rh1, ml1}) * 53'(RECIP45);
  end

  // stage 3: assemble quotient and restore sign, modulo one turn
  always_comb begin
    q3 = {qh2[11:0], 20'd0} + 32'(pl2[52:32]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v2;
    end
    turn <= neg2 ? (~q3 + 1'b1) : q3;
  end

endmodule

`default_nettype wire

>>> rtl/btf_sincos.sv
// Rotation-mode CORDIC pipeline: sine and cosine of a binary turn angle.
`default_nettype none

module btf_sincos import btf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic [TURN_W-1:0]       angle,
  output logic                    out_valid,
  output logic signed [31:0]      sin_out,
  output logic signed [31:0]      cos_out
);

  logic              v_q    [0:CORDIC_STAGES];
  logic              flip_q [0:CORDIC_STAGES];
  logic signed [31:0] x_q   [0:CORDIC_STAGES];
  logic signed [31:0] y_q   [0:CORDIC_STAGES];
  logic signed [32:0] z_q   [0:CORDIC_STAGES];

  logic [TURN_W-1:0] a_plus;
  logic [TURN_W-1:0] a_fold;
  logic              flip_in;

  // fold the back half-plane onto the front one
  always_comb begin
    a_plus  = angle + QUARTER_TURN;
    flip_in = a_plus[TURN_W-1];
    a_fold  = flip_in ? (angle ^ HALF_TURN) : angle;
  end

  // entry stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= in_valid;
    end
    flip_q[0] <= flip_in;
    x_q[0]    <= CORDIC_GAIN;
    y_q[0]    <= '0;
    z_q[0]    <= {a_fold[TURN_W-1], a_fold};
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [32:0] za;

    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    assign za = {1'b0, TURN_ATAN[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[i+1] <= 1'b0;
      end else begin
        v_q[i+1] <= v_q[i];
      end
      flip_q[i+1] <= flip_q[i];
      if (!z_q[i][32]) begin
        x_q[i+1] <= x_q[i] - dx;
        y_q[i+1] <= y_q[i] + dy;
        z_q[i+1] <= z_q[i] - za;
      end else begin
        x_q[i+1] <= x_q[i] + dx;
        y_q[i+1] <= y_q[i] - dy;
        z_q[i+1] <= z_q[i] + za;
      end
    end
  end

  // undo the fold
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v_q[CORDIC_STAGES];
    end
    sin_out <= flip_q[CORDIC_STAGES] ? -y_q[CORDIC_STAGES] : y_q[CORDIC_STAGES];
    cos_out <= flip_q[CORDIC_STAGES] ? -x_q[CORDIC_STAGES] : x_q[CORDIC_STAGES];
  end

endmodule

`default_nettype wire

>>> rtl/bearing_to_fixed_point.sv
// Initial great-circle bearing from an observer to a configurable target point.
// Throughput: one position per cycle while busy is low; pipeline depth is set
// mainly by the two 18-stage CORDIC chains that each position passes in series.
// busy is high only in reset and the cycle after it; results cannot be held off.
// Reset clears all valid bits and loads the default target point.
`default_nettype none

module bearing_to_fixed_point import btf_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [LAT_W-1:0]     observer_latitude,
  input  logic signed [LON_W-1:0]     observer_longitude,
  output logic                        done,
  output logic [FINE_W-1:0]           bearing_fine,
  output logic [WHOLE_W-1:0]          bearing_whole,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  logic [LAT_W-1:0] target_latitude;
  logic [LON_W-1:0] target_longitude;

  logic                    s0_valid;
  logic signed [DEG_W-1:0] olat_s0, tlat_s0, dlon_s0;

  logic              tv;
  logic [TURN_W-1:0] turn_ol, turn_tl, turn_dl;

  logic               scv;
  logic signed [31:0] sl, cl, st, ct, sd, cd;

  logic               m1_valid, m2_valid, m3_valid;
  logic signed [63:0] p_y, p_a, p_b, p_c;
  logic signed [31:0] sl_m1, y_m2, a_m2, y_m3;
  logic signed [32:0] x_m3;

  logic               vv    [0:CORDIC_STAGES];
  logic               vzero [0:CORDIC_STAGES];
  logic signed [35:0] vx    [0:CORDIC_STAGES];
  logic signed [35:0] vy    [0:CORDIC_STAGES];
  logic [TURN_W-1:0]  vz    [0:CORDIC_STAGES];

  logic signed [35:0] xe, ye;
  logic [TURN_W-1:0]  turn_o;
  logic [48:0]        fine_p;
  logic [40:0]        whole_p;
  logic               o1_valid;
  logic [FINE_W-1:0]  fine_raw;
  logic [WHOLE_W-1:0] whole_raw;

  // always ready once out of reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign cfg_ready = !busy;

  // target point registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target_latitude  <= TARGET_LAT_RESET;
      target_longitude <= TARGET_LON_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TARGET_LAT: target_latitude  <= cfg_data[LAT_W-1:0];
        REG_TARGET_LON: target_longitude <= cfg_data[LON_W-1:0];
        default: ;
      endcase
    end
  end

  // input stage: sign-extend, longitude difference
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= start && !busy;
    end
    olat_s0 <= DEG_W'(observer_latitude);
    tlat_s0 <= DEG_W'($signed(target_latitude));
    dlon_s0 <= DEG_W'($signed(target_longitude)) - DEG_W'(observer_longitude);
  end

  // degrees to binary turns
  btf_turn u_turn_ol (
    .clk(clk), .rst(rst), .in_valid(s0_valid), .deg(olat_s0),
    .out_valid(tv), .turn(turn_ol)
  );
  btf_turn u_turn_tl (
    .clk(clk), .rst(rst), .in_valid(s0_valid), .deg(tlat_s0),
    .out_valid(), .turn(turn_tl)
  );
  btf_turn u_turn_dl (
    .clk(clk), .rst(rst), .in_valid(s0_valid), .deg(dlon_s0),
    .out_valid(), .turn(turn_dl)
  );

  // sine and cosine of each angle
  btf_sincos u_sc_ol (
    .clk(clk), .rst(rst), .in_valid(tv), .angle(turn_ol),
    .out_valid(scv), .sin_out(sl), .cos_out(cl)
  );
  btf_sincos u_sc_tl (
    .clk(clk), .rst(rst), .in_valid(tv), .angle(turn_tl),
    .out_valid(), .sin_out(st), .cos_out(ct)
  );
  btf_sincos u_sc_dl (
    .clk(clk), .rst(rst), .in_valid(tv), .angle(turn_dl),
    .out_valid(), .sin_out(sd), .cos_out(cd)
  );

  // products: y = sd*ct, x = cl*st - sl*(ct*cd), 30 fraction bits, floored
  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
      m3_valid <= 1'b0;
    end else begin
      m1_valid <= scv;
      m2_valid <= m1_valid;
      m3_valid <= m2_valid;
    end
    p_y   <= sd * ct;
    p_a   <= cl * st;
    p_b   <= ct * cd;
    sl_m1 <= sl;
    y_m2  <= p_y[61:30];
    a_m2  <= p_a[61:30];
    p_c   <= sl_m1 * $signed(p_b[61:30]);
    y_m3  <= y_m2;
    x_m3  <= {a_m2[31], a_m2} - p_c[62:30];
  end

  // vectoring entry: move x into the right half-plane
  always_comb begin
    xe = 36'(x_m3);
    ye = 36'(y_m3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vv[0] <= 1'b0;
    end else begin
      vv[0] <= m3_valid;
    end
    vzero[0] <= (x_m3 == '0) && (y_m3 == '0);
    if (x_m3[32]) begin
      vx[0] <= -xe;
      vy[0] <= -ye;
      vz[0] <= HALF_TURN;
    end else begin
      vx[0] <= xe;
      vy[0] <= ye;
      vz[0] <= '0;
    end
  end

  // vectoring micro-rotations
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
    logic signed [35:0] dx;
    logic signed [35:0] dy;
    logic               ypos;

    assign dx   = vy[i] >>> i;
    assign dy   = vx[i] >>> i;
    assign ypos = !vy[i][35] && (vy[i] != '0);

    always_ff @(posedge clk) begin
      if (rst) begin
        vv[i+1] <= 1'b0;
      end else begin
        vv[i+1] <= vv[i];
      end
      vzero[i+1] <= vzero[i];
      if (ypos) begin
        vx[i+1] <= vx[i] + dx;
        vy[i+1] <= vy[i] - dy;
        vz[i+1] <= vz[i] + TURN_ATAN[i];
      end else begin
        vx[i+1] <= vx[i] - dx;
        vy[i+1] <= vy[i] + dy;
        vz[i+1] <= vz[i] - TURN_ATAN[i];
      end
    end
  end

  // scale turn to 1/256 degree and whole degrees, halves up
  always_comb begin
    turn_o  = vzero[CORDIC_STAGES] ? '0 : vz[CORDIC_STAGES];
    fine_p  = 49'(turn_o) * 49'(FINE_STEPS) + 49'(HALF_TURN);
    whole_p = 41'(turn_o) * 41'(WHOLE_STEPS) + 41'(HALF_TURN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o1_valid <= 1'b0;
    end else begin
      o1_valid <= vv[CORDIC_STAGES];
    end
    fine_raw  <= fine_p[48:32];
    whole_raw <= whole_p[40:32];
  end

  // full circle wraps to zero
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= o1_valid;
    end
    bearing_fine  <= (fine_raw >= FINE_STEPS) ? '0 : fine_raw;
    bearing_whole <= (whole_raw >= WHOLE_STEPS) ? '0 : whole_raw;
  end

endmodule

`default_nettype wire

>>> rtl/btf_checker.sv
// Port-level checks for the bearing block, bound to the top level.
`default_nettype none

module btf_checker import btf_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic                 done,
  input wire logic [FINE_W-1:0]    bearing_fine,
  input wire logic [WHOLE_W-1:0]   bearing_whole,
  input wire logic                 cfg_ready
);

  // reset flushes the pipeline and holds off new work
  a_reset_flush: assert property (@(posedge clk) rst |=> (!done && busy))
    else $error("done or ready after reset");

  // pipeline never blocks once out of reset
  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    !rst |=> (!busy && cfg_ready))
    else $error("block not ready");

  // each result follows its start by the fixed pipeline latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without matching start");

  // results lie within one turn
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (bearing_fine < FINE_STEPS) && (bearing_whole < WHOLE_STEPS))
    else $error("bearing out of range");

endmodule

bind bearing_to_fixed_point btf_checker u_btf_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .done(done),
  .bearing_fine(bearing_fine),
  .bearing_whole(bearing_whole),
  .cfg_ready(cfg_ready)
);

`default_nettype wire

>>> verif/bearing_checker.sv
// Checker for the bearing block: tracks the target point, predicts each bearing, compares.
`default_nettype none

module bearing_checker import btf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    busy,
  input  logic [LAT_W-1:0]        observer_latitude,
  input  logic [LON_W-1:0]        observer_longitude,
  input  logic                    done,
  input  logic [FINE_W-1:0]       bearing_fine,
  input  logic [WHOLE_W-1:0]      bearing_whole,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  output int                      fail_count,
  output int                      bearings_pending
);

  typedef struct packed {
    logic [FINE_W-1:0]  fine;
    logic [WHOLE_W-1:0] whole;
  } bearing_t;

  bearing_t         bearing_q[$];
  logic [LAT_W-1:0] tgt_lat;
  logic [LON_W-1:0] tgt_lon;

  assign bearings_pending = bearing_q.size();

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // Degrees (16 fraction bits) to binary turn angle, halves away from zero
  function automatic logic [31:0] turn_of_deg(input longint deg);
    longint unsigned mag, den, q;
    mag = (deg < 0) ? longint'(-deg) : longint'(deg);
    den = 64'd360 << 16;
    q = ((mag << 32) + den / 2) / den;
    if (deg < 0) q = ~q + 1;
    return q[31:0];
  endfunction

  // Rotation-mode CORDIC with half-turn folding
  function automatic void cordic_sin_cos(input logic [31:0] a, output longint s,
                                         output longint c);
    logic   flip;
    logic [31:0] sum;
    longint x, y, z, dx, dy;
    sum = a + QUARTER_TURN;
    flip = sum[31];
    if (flip) a = a ^ HALF_TURN;
    z = longint'(signed'(a));
    x = longint'(CORDIC_GAIN);
    y = 0;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(TURN_ATAN[i]);
      end else begin
        x += dx; y -= dy; z += longint'(TURN_ATAN[i]);
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  // Vectoring CORDIC, angle accumulated in turn units
  function automatic logic [31:0] cordic_atan2(input longint y, input longint x);
    longint z, nx;
    z = 0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      x = -x; y = -y; z = 64'sd2147483648;
    end
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); y -= (x >>> i); z += longint'(TURN_ATAN[i]);
      end else begin
        nx = x - (y >>> i); y += (x >>> i); z -= longint'(TURN_ATAN[i]);
      end
      x = nx;
    end
    return z[31:0];
  endfunction

  function automatic longint q30_mul(input longint a, input longint b);
    return (a * b) >>> 30;
  endfunction

  function automatic bearing_t predict_bearing(input logic [LAT_W-1:0] lat,
                                               input logic [LON_W-1:0] lon);
    longint   olat, olon, tlat, tlon, sl, cl, st, ct, sd, cd, y, x;
    longint unsigned turn, f, w;
    bearing_t b;
    olat = longint'(signed'(lat));
    olon = longint'(signed'(lon));
    tlat = longint'(signed'(tgt_lat));
    tlon = longint'(signed'(tgt_lon));
    cordic_sin_cos(turn_of_deg(olat), sl, cl);
    cordic_sin_cos(turn_of_deg(tlat), st, ct);
    cordic_sin_cos(turn_of_deg(tlon - olon), sd, cd);
    y = q30_mul(sd, ct);
    x = q30_mul(cl, st) - q30_mul(sl, q30_mul(ct, cd));
    turn = {32'd0, cordic_atan2(y, x)};
    f = (turn * 92160 + 64'h8000_0000) >> 32;
    if (f >= 92160) f = 0;
    w = (turn * 360 + 64'h8000_0000) >> 32;
    if (w >= 360) w = 0;
    b.fine = f[FINE_W-1:0];
    b.whole = w[WHOLE_W-1:0];
    return b;
  endfunction

  initial fail_count = 0;

  // Register writes, input transfers and result checks
  always @(posedge clk) begin
    bearing_t got, want;
    if (rst) begin
      tgt_lat <= TARGET_LAT_RESET;
      tgt_lon <= TARGET_LON_RESET;
      bearing_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_TARGET_LAT) tgt_lat <= cfg_data[LAT_W-1:0];
        else if (cfg_index == REG_TARGET_LON) tgt_lon <= cfg_data[LON_W-1:0];
      end
      if (start && !busy)
        bearing_q.push_back(predict_bearing(observer_latitude, observer_longitude));
      if (done) begin
        got.fine = bearing_fine;
        got.whole = bearing_whole;
        if (bearing_q.size() == 0) begin
          report_mismatch($sformatf("unexpected bearing %0d/%0d", got.fine, got.whole));
        end else begin
          want = bearing_q.pop_front();
          if (got.fine !== want.fine)
            report_mismatch($sformatf("bearing_fine %0d, want %0d", got.fine, want.fine));
          if (got.whole !== want.whole)
            report_mismatch($sformatf("bearing_whole %0d, want %0d",
                                      got.whole, want.whole));
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> verif/tb_bearing_to_fixed_point.sv
// Testbench top: drives positions and target settings, then gives the verdict.
`default_nettype none

module tb_bearing_to_fixed_point;
  import btf_pkg::*;

  localparam int LAT_MAX = 5898240;
  localparam int LON_MAX = 11796480;

  logic                  clk, rst, start, busy, done, cfg_valid, cfg_ready;
  logic [LAT_W-1:0]      observer_latitude;
  logic [LON_W-1:0]      observer_longitude;
  logic [FINE_W-1:0]     bearing_fine;
  logic [WHOLE_W-1:0]    bearing_whole;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count, bearings_pending;

  bearing_to_fixed_point dut (.*);
  bearing_checker chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(20 * 2000000);
    $display("bearing_to_fixed_point test failed");
    $finish;
  end

  // Random gap: mostly none, sometimes short, rarely long
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_position(input logic [LAT_W-1:0] lat, input logic [LON_W-1:0] lon);
    int g;
    start <= 1'b1;
    observer_latitude <= lat;
    observer_longitude <= lon;
    @(posedge clk);
    while (busy) @(posedge clk);
    g = gap_len();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Drain the pipe, then write one register
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    start <= 1'b0;
    @(posedge clk);
    while (bearings_pending != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [LAT_W-1:0] rand_lat();
    if ($urandom_range(9) == 0) return LAT_W'($urandom);
    return LAT_W'($signed($urandom_range(2 * LAT_MAX)) - LAT_MAX);
  endfunction

  function automatic logic [LON_W-1:0] rand_lon();
    if ($urandom_range(9) == 0) return LON_W'($urandom);
    return LON_W'($signed($urandom_range(2 * LON_MAX)) - LON_MAX);
  endfunction

  initial begin
    logic [LAT_W-1:0] lat_set [8];
    logic [LON_W-1:0] lon_set [8];
    start = 0; cfg_valid = 0; cfg_index = REG_TARGET_LAT; cfg_data = '0;
    observer_latitude = '0; observer_longitude = '0;
    rst = 1;
    repeat (8) @(posedge clk);
    rst <= 0;

    // Directed: field extremes, observer at the target, poles and equator
    send_position(LAT_W'(LAT_MAX), '0);
    send_position(LAT_W'(-LAT_MAX), '0);
    send_position('0, LON_W'(LON_MAX));
    send_position('0, LON_W'(-LON_MAX));
    send_position(LAT_W'(LAT_MAX), LON_W'(LON_MAX));
    send_position(LAT_W'(-LAT_MAX), LON_W'(-LON_MAX));
    send_position('0, '0);
    send_position(TARGET_LAT_RESET, TARGET_LON_RESET);
    send_position(TARGET_LAT_RESET, TARGET_LON_RESET + LON_W'(LON_MAX));
    send_position({1'b0, {(LAT_W-1){1'b1}}}, {1'b0, {(LON_W-1){1'b1}}});
    send_position({1'b1, {(LAT_W-1){1'b0}}}, {1'b1, {(LON_W-1){1'b0}}});
    send_position('1, '1);
    send_position(24'd1, 25'd1);

    // Equator target: observer on the equator gives a zero x term
    write_reg(REG_TARGET_LAT, '0);
    write_reg(REG_TARGET_LON, '0);
    send_position('0, '0);
    send_position('0, LON_W'(LON_MAX / 2));
    send_position('0, LON_W'(LON_MAX));
    // Unused register indexes must be ignored
    write_reg(2'd2, '1);
    write_reg(2'd3, 25'h0AAAAAA);
    send_position('0, '0);
    send_position(LAT_W'(LAT_MAX / 3), LON_W'(-LON_MAX / 5));

    // Target settings for the random phases, extremes among them
    lat_set = '{TARGET_LAT_RESET, LAT_W'(LAT_MAX), LAT_W'(-LAT_MAX), '0,
                {1'b0, {(LAT_W-1){1'b1}}}, {1'b1, {(LAT_W-1){1'b0}}},
                LAT_W'(LAT_MAX / 2), LAT_W'($urandom)};
    lon_set = '{TARGET_LON_RESET, LON_W'(LON_MAX), LON_W'(-LON_MAX), '0,
                {1'b0, {(LON_W-1){1'b1}}}, {1'b1, {(LON_W-1){1'b0}}},
                LON_W'(-LON_MAX / 3), LON_W'($urandom)};
    for (int p = 0; p < 8; p++) begin
      write_reg(REG_TARGET_LAT, CFG_DATA_W'(lat_set[p]));
      write_reg(REG_TARGET_LON, lon_set[p]);
      for (int n = 0; n < 100; n++) send_position(rand_lat(), rand_lon());
    end

    start <= 1'b0;
    @(posedge clk);
    while (bearings_pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("bearing_to_fixed_point test passed");
    end else begin
      $display("bearing_to_fixed_point test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
